// ===== rtl/alu_with_status_flags_assert.svh =====
// ----------------------------------------------------------------------------
// alu_with_status_flags assertion macros
// Concurrent check wrappers clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ALU_WITH_STATUS_FLAGS_ASSERT_SVH
`define ALU_WITH_STATUS_FLAGS_ASSERT_SVH

// same-cycle implication
`define AWSF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define AWSF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/awsf_pkg.sv =====
// ----------------------------------------------------------------------------
// awsf_pkg
// Shared types and constants of the byte/word ALU with status flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package awsf_pkg;

    localparam int DATA_W    = 16;
    localparam int DIV_STEPS = DATA_W;  // one quotient bit per stage

    // status word bit positions
    localparam int FLAG_Z = 0;
    localparam int FLAG_O = 1;
    localparam int FLAG_C = 2;
    localparam int FLAG_N = 3;

    typedef enum logic [3:0] {
        OP_MOV  = 4'd0,
        OP_ADD  = 4'd1,
        OP_SUB  = 4'd2,
        OP_MUL  = 4'd3,
        OP_DIV  = 4'd4,
        OP_CMP  = 4'd5,
        OP_NOT  = 4'd6,
        OP_AND  = 4'd7,
        OP_OR   = 4'd8,
        OP_XOR  = 4'd9,
        OP_TEST = 4'd10,
        OP_SHL  = 4'd11,
        OP_SHR  = 4'd12
    } op_t;

    typedef struct packed {
        logic [3:0]        mode;
        logic              wide;
        logic [DATA_W-1:0] source_value;
        logic [DATA_W-1:0] dest_value;
        logic [DATA_W-1:0] flags_in;
    } req_t;

    typedef struct packed {
        logic [DATA_W-1:0] res;
        logic              wb;
        logic [DATA_W-1:0] flags;
        logic              zn;
        logic              is_div;
        logic              div_zero;
        logic              div_neg;
        logic              wide;
    } exec_t;

    typedef struct packed {
        logic [DATA_W-1:0] rem;
        logic [DATA_W-1:0] quo;
        logic [DATA_W-1:0] divisor;
    } div_t;

    typedef struct packed {
        exec_t ex;
        div_t  dv;
    } stage_t;

endpackage

`default_nettype wire

// ===== rtl/awsf_req_if.sv =====
// ----------------------------------------------------------------------------
// awsf_req_if
// Operation channel: valid/ready handshake with the operand word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface awsf_req_if;
    logic                      valid;
    logic                      ready;
    logic [3:0]                mode;
    logic                      wide;
    logic [awsf_pkg::DATA_W-1:0] source_value;
    logic [awsf_pkg::DATA_W-1:0] dest_value;
    logic [awsf_pkg::DATA_W-1:0] flags_in;

    modport source (output valid, mode, wide, source_value, dest_value, flags_in,
                    input ready);
    modport sink   (input valid, mode, wide, source_value, dest_value, flags_in,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/awsf_rsp_if.sv =====
// ----------------------------------------------------------------------------
// awsf_rsp_if
// Result channel: valid/ready handshake with the result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface awsf_rsp_if;
    logic                      valid;
    logic                      ready;
    logic [awsf_pkg::DATA_W-1:0] result_value;
    logic                      write_back;
    logic [awsf_pkg::DATA_W-1:0] flags_out;
    logic                      divide_fault;

    modport source (output valid, result_value, write_back, flags_out, divide_fault,
                    input ready);
    modport sink   (input valid, result_value, write_back, flags_out, divide_fault,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/awsf_exec.sv =====
// ----------------------------------------------------------------------------
// awsf_exec
// Combinational operations, flag updates and divider operand preparation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module awsf_exec (
    input  awsf_pkg::req_t   req,
    output awsf_pkg::stage_t stg
);

    logic [awsf_pkg::DATA_W-1:0]   mask;
    logic [awsf_pkg::DATA_W-1:0]   s;
    logic [awsf_pkg::DATA_W-1:0]   d;
    logic                          s_sign;
    logic                          d_sign;
    logic [4:0]                    cnt;
    logic [awsf_pkg::DATA_W-1:0]   sum;
    logic [awsf_pkg::DATA_W-1:0]   dif;
    logic [awsf_pkg::DATA_W-1:0]   prod;
    logic [2*awsf_pkg::DATA_W-1:0] shl_full;
    logic [awsf_pkg::DATA_W-1:0]   shr_val;
    logic [awsf_pkg::DATA_W-1:0]   low_mask;
    logic                          sum_sign;
    logic                          dif_sign;

    always_comb
    begin
        mask     = req.wide ? 16'hFFFF : 16'h00FF;
        s        = req.source_value & mask;
        d        = req.dest_value & mask;
        s_sign   = req.wide ? s[15] : s[7];
        d_sign   = req.wide ? d[15] : d[7];
        cnt      = (s > 16'd16) ? 5'd16 : s[4:0];
        sum      = d + s;
        dif      = d - s;
        prod     = d * s;
        shl_full = {16'h0000, d} << cnt;
        shr_val  = req.wide ? 16'($signed(d) >>> cnt) : (d >> cnt);
        low_mask = ~(16'hFFFF << cnt);
        sum_sign = req.wide ? sum[15] : sum[7];
        dif_sign = req.wide ? dif[15] : dif[7];

        stg.ex.res      = '0;
        stg.ex.wb       = 1'b1;
        stg.ex.flags    = req.flags_in;
        stg.ex.zn       = 1'b1;
        stg.ex.is_div   = 1'b0;
        stg.ex.div_zero = (s == '0);
        stg.ex.div_neg  = req.wide & (d[15] ^ s[15]);
        stg.ex.wide     = req.wide;

        case (awsf_pkg::op_t'(req.mode))
            awsf_pkg::OP_MOV:
            begin
                stg.ex.res = s;
            end
            awsf_pkg::OP_ADD:
            begin
                stg.ex.res = sum & mask;
                stg.ex.flags[awsf_pkg::FLAG_O] = (s_sign == d_sign) && (sum_sign != d_sign);
                stg.ex.flags[awsf_pkg::FLAG_C] = 1'b0;
            end
            awsf_pkg::OP_SUB, awsf_pkg::OP_CMP:
            begin
                stg.ex.res = dif & mask;
                stg.ex.flags[awsf_pkg::FLAG_O] = (s_sign != d_sign) && (dif_sign != d_sign);
                stg.ex.flags[awsf_pkg::FLAG_C] = 1'b0;
                stg.ex.wb  = (req.mode != awsf_pkg::OP_CMP);
            end
            awsf_pkg::OP_MUL:
            begin
                stg.ex.res = prod & mask;
            end
            awsf_pkg::OP_DIV:
            begin
                // quotient is filled in after the divide stages
                stg.ex.is_div = 1'b1;
                stg.ex.wb     = ~stg.ex.div_zero;
                stg.ex.zn     = ~stg.ex.div_zero;
            end
            awsf_pkg::OP_NOT:
            begin
                stg.ex.res = ~s & mask;
            end
            awsf_pkg::OP_AND:
            begin
                stg.ex.res = d & s;
            end
            awsf_pkg::OP_OR:
            begin
                stg.ex.res = d | s;
            end
            awsf_pkg::OP_XOR:
            begin
                stg.ex.res = d ^ s;
            end
            awsf_pkg::OP_TEST:
            begin
                stg.ex.res = d & s;
                stg.ex.wb  = 1'b0;
            end
            awsf_pkg::OP_SHL:
            begin
                stg.ex.res = shl_full[15:0] & mask;
                stg.ex.flags[awsf_pkg::FLAG_C] = req.wide ? (|shl_full[31:16])
                                                          : (|shl_full[31:8]);
            end
            awsf_pkg::OP_SHR:
            begin
                stg.ex.res = shr_val & mask;
                stg.ex.flags[awsf_pkg::FLAG_C] = |(d & low_mask);
            end
            default:
            begin
                stg.ex.wb = 1'b0;
                stg.ex.zn = 1'b0;
            end
        endcase

        // divider works on magnitudes; sign restored at the end
        stg.dv.rem     = '0;
        stg.dv.quo     = (req.wide && d[15]) ? 16'(16'h0000 - d) : d;
        stg.dv.divisor = (req.wide && s[15]) ? 16'(16'h0000 - s) : s;
    end

endmodule

`default_nettype wire

// ===== rtl/awsf_div_step.sv =====
// ----------------------------------------------------------------------------
// awsf_div_step
// One restoring division step: shifts in a dividend bit, yields a quotient bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module awsf_div_step (
    input  awsf_pkg::div_t cur,
    output awsf_pkg::div_t nxt
);

    logic [awsf_pkg::DATA_W:0] trial;
    logic [awsf_pkg::DATA_W:0] dvsr;
    logic                      ge;

    always_comb
    begin
        trial = {cur.rem, cur.quo[awsf_pkg::DATA_W-1]};
        dvsr  = {1'b0, cur.divisor};
        ge    = (trial >= dvsr);
        // remainder stays below the divisor, so 16 bits hold it
        nxt.rem     = ge ? 16'(trial - dvsr) : trial[awsf_pkg::DATA_W-1:0];
        nxt.quo     = {cur.quo[awsf_pkg::DATA_W-2:0], ge};
        nxt.divisor = cur.divisor;
    end

endmodule

`default_nettype wire

// ===== rtl/alu_with_status_flags.sv =====
// ----------------------------------------------------------------------------
// alu_with_status_flags: byte/word ALU with Z/O/C/N status update
// Throughput one word per cycle while the output is not stalled; a word passes the input
// register, execute and the 16 one-bit restoring divide stages on its way to the output.
// Stalls back up stage by stage; empty stages keep filling. Reset clears valid bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "alu_with_status_flags_assert.svh"

module alu_with_status_flags (
    input  wire logic   clk,
    input  wire logic   rst_n,
    awsf_req_if.sink    req,
    awsf_rsp_if.source  rsp
);

    localparam int LAST = awsf_pkg::DIV_STEPS;

    awsf_pkg::req_t   in_reg;
    logic             in_v_reg;
    awsf_pkg::req_t   in_word;
    awsf_pkg::stage_t exec_stg;
    awsf_pkg::stage_t pipe_reg [0:LAST];
    logic [LAST:0]    pv_reg;
    awsf_pkg::div_t   step_dv  [0:LAST-1];
    logic [LAST:0]    pen;
    logic             in_en;
    logic             out_en;
    logic             ov_reg;

    logic [awsf_pkg::DATA_W-1:0] res_reg;
    logic                        wb_reg;
    logic [awsf_pkg::DATA_W-1:0] flags_reg;
    logic                        fault_reg;

    logic [awsf_pkg::DATA_W-1:0] res_next;
    logic [awsf_pkg::DATA_W-1:0] flags_next;
    logic                        fault_next;
    logic [awsf_pkg::DATA_W-1:0] quo_signed;
    awsf_pkg::stage_t            last_stg;

    assign in_word.mode         = req.mode;
    assign in_word.wide         = req.wide;
    assign in_word.source_value = req.source_value;
    assign in_word.dest_value   = req.dest_value;
    assign in_word.flags_in     = req.flags_in;

    // a stage moves when it is empty or the one after it moves
    assign out_en    = ~ov_reg | rsp.ready;
    assign pen[LAST] = ~pv_reg[LAST] | out_en;
    genvar g;
    generate
        for (g = 0; g < LAST; g++)
        begin : g_en
            assign pen[g] = ~pv_reg[g] | pen[g+1];
        end
    endgenerate
    assign in_en     = ~in_v_reg | pen[0];
    assign req.ready = in_en;

    awsf_exec u_exec (
        .req (in_reg),
        .stg (exec_stg)
    );

    generate
        for (g = 0; g < LAST; g++)
        begin : g_div
            awsf_div_step u_step (
                .cur (pipe_reg[g].dv),
                .nxt (step_dv[g])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg <= 1'b0;
            pv_reg   <= '0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            if (in_en)
            begin
                in_v_reg <= req.valid;
            end
            if (pen[0])
            begin
                pv_reg[0] <= in_v_reg;
            end
            for (int k = 1; k <= LAST; k++)
            begin
                if (pen[k])
                begin
                    pv_reg[k] <= pv_reg[k-1];
                end
            end
            if (out_en)
            begin
                ov_reg <= pv_reg[LAST];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_en)
        begin
            in_reg <= in_word;
        end
        if (pen[0])
        begin
            pipe_reg[0] <= exec_stg;
        end
        for (int k = 1; k <= LAST; k++)
        begin
            if (pen[k])
            begin
                pipe_reg[k].ex <= pipe_reg[k-1].ex;
                pipe_reg[k].dv <= step_dv[k-1];
            end
        end
        if (out_en)
        begin
            res_reg   <= res_next;
            wb_reg    <= pipe_reg[LAST].ex.wb;
            flags_reg <= flags_next;
            fault_reg <= fault_next;
        end
    end

    // output stage: restore quotient sign, then Z and N at operand width
    always_comb
    begin
        last_stg   = pipe_reg[LAST];
        quo_signed = last_stg.ex.div_neg ? 16'(16'h0000 - last_stg.dv.quo)
                                         : last_stg.dv.quo;
        fault_next = last_stg.ex.is_div & last_stg.ex.div_zero;
        if (last_stg.ex.is_div && !last_stg.ex.div_zero)
        begin
            res_next = quo_signed & (last_stg.ex.wide ? 16'hFFFF : 16'h00FF);
        end
        else
        begin
            res_next = last_stg.ex.res;
        end
        flags_next = last_stg.ex.flags;
        if (last_stg.ex.zn)
        begin
            flags_next[awsf_pkg::FLAG_Z] = (res_next == '0);
            flags_next[awsf_pkg::FLAG_N] = last_stg.ex.wide ? res_next[15] : res_next[7];
        end
    end

    assign rsp.valid        = ov_reg;
    assign rsp.result_value = res_reg;
    assign rsp.write_back   = wb_reg;
    assign rsp.flags_out    = flags_reg;
    assign rsp.divide_fault = fault_reg;

    `AWSF_ASSERT_SAME(a_full_when_blocked, !req.ready,
        in_v_reg && (&pv_reg) && ov_reg, "input blocked while a stage is empty")
    `AWSF_ASSERT_SAME(a_out_from_pipe, $rose(ov_reg),
        $past(pv_reg[LAST]), "result valid without a word in the last stage")
    `AWSF_ASSERT_SAME(a_fault_no_wb, ov_reg && fault_reg,
        !wb_reg && (res_reg == '0), "divide fault with write-back or nonzero result")
    `AWSF_ASSERT_NEXT(a_last_holds, pv_reg[LAST] && !pen[LAST],
        pv_reg[LAST] && $stable(pipe_reg[LAST]), "stalled last stage lost its word")

endmodule

`default_nettype wire

// ===== bench/tb_alu_with_status_flags.sv =====
// ----------------------------------------------------------------------------
// tb_alu_with_status_flags
// Self-checking bench for the byte/word ALU. Operations go in through a bursty
// driver, results are taken by a monitor that stalls on its own pattern. Each
// accepted word is predicted here and compared field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_alu_with_status_flags;

    localparam int          CLK_PERIOD     = 20;
    localparam int          RESET_CYCLES   = 12;
    localparam int          CYCLE_LIMIT    = 300000;
    localparam int          SETTLE_CYCLES  = 40;
    localparam int          RANDOM_FIRST   = 900;
    localparam int          RANDOM_SECOND  = 950;
    localparam logic [3:0]  MODE_SPARE_LO  = 4'd13;  // unassigned codes: no-op
    localparam logic [3:0]  MODE_SPARE_HI  = 4'd15;

    typedef struct packed {
        logic [awsf_pkg::DATA_W-1:0] result_value;
        logic                        write_back;
        logic [awsf_pkg::DATA_W-1:0] flags_out;
        logic                        divide_fault;
    } alu_outcome_t;

    logic clk;
    logic rst_n;

    awsf_req_if req_ch ();
    awsf_rsp_if rsp_ch ();

    alu_with_status_flags dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    awsf_pkg::req_t pending_ops[$];
    alu_outcome_t   expected_outcomes[$];
    int             mismatch_count;
    int             cycle_count;

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic alu_outcome_t alu_outcome(input awsf_pkg::req_t op);
        logic [awsf_pkg::DATA_W-1:0] mask;
        logic [awsf_pkg::DATA_W-1:0] sign_bit;
        logic [awsf_pkg::DATA_W-1:0] s;
        logic [awsf_pkg::DATA_W-1:0] d;
        logic [awsf_pkg::DATA_W-1:0] r;
        logic [awsf_pkg::DATA_W-1:0] flags;
        logic [awsf_pkg::DATA_W-1:0] lost;
        logic [awsf_pkg::DATA_W-1:0] low_bits;
        logic                        wb;
        logic                        fault;
        logic                        zn;
        int unsigned                 width;
        int unsigned                 cnt;
        int                          sd;
        int                          ss;
        alu_outcome_t                o;

        mask     = op.wide ? 16'hFFFF : 16'h00FF;
        sign_bit = op.wide ? 16'h8000 : 16'h0080;
        width    = op.wide ? 16 : 8;
        s        = op.source_value & mask;
        d        = op.dest_value & mask;
        flags    = op.flags_in;
        r        = '0;
        wb       = 1'b1;
        fault    = 1'b0;
        zn       = 1'b1;
        cnt      = (s > 16) ? 16 : s;

        case (op.mode)
            awsf_pkg::OP_MOV: r = s;
            awsf_pkg::OP_ADD:
            begin
                r = (d + s) & mask;
                flags[awsf_pkg::FLAG_O] = ((s & sign_bit) == (d & sign_bit)) &&
                                          ((r & sign_bit) != (d & sign_bit));
                flags[awsf_pkg::FLAG_C] = 1'b0;
            end
            awsf_pkg::OP_SUB, awsf_pkg::OP_CMP:
            begin
                r = (d - s) & mask;
                flags[awsf_pkg::FLAG_O] = ((s & sign_bit) != (d & sign_bit)) &&
                                          ((r & sign_bit) != (d & sign_bit));
                flags[awsf_pkg::FLAG_C] = 1'b0;
                wb = (op.mode != awsf_pkg::OP_CMP);
            end
            awsf_pkg::OP_MUL: r = (d * s) & mask;
            awsf_pkg::OP_DIV:
            begin
                if (s == 0)
                begin
                    fault = 1'b1;
                    wb    = 1'b0;
                    zn    = 1'b0;
                end
                else if (op.wide)
                begin
                    sd = $signed(d);
                    ss = $signed(s);
                    r  = 16'(sd / ss);    // -32768 / -1 wraps to 0x8000
                end
                else
                begin
                    r = d / s;
                end
            end
            awsf_pkg::OP_NOT:  r = ~s & mask;
            awsf_pkg::OP_AND:  r = d & s;
            awsf_pkg::OP_OR:   r = d | s;
            awsf_pkg::OP_XOR:  r = d ^ s;
            awsf_pkg::OP_TEST:
            begin
                r  = d & s;
                wb = 1'b0;
            end
            awsf_pkg::OP_SHL:
            begin
                r    = (d << cnt) & mask;
                lost = '0;
                if (cnt != 0)
                    lost = (cnt >= width) ? d : (d >> (width - cnt));
                flags[awsf_pkg::FLAG_C] = (lost != 0);
            end
            awsf_pkg::OP_SHR:
            begin
                low_bits = (cnt >= 16) ? 16'hFFFF : 16'((32'd1 << cnt) - 1);
                if (op.wide && d[15])
                    r = (cnt >= 16) ? 16'hFFFF : 16'($signed(d) >>> cnt);
                else
                    r = (cnt >= 16) ? 16'h0000 : (d >> cnt);
                r = r & mask;
                flags[awsf_pkg::FLAG_C] = ((d & low_bits) != 0);
            end
            default:
            begin
                wb = 1'b0;
                zn = 1'b0;
            end
        endcase

        if (zn)
        begin
            flags[awsf_pkg::FLAG_Z] = (r == 0);
            flags[awsf_pkg::FLAG_N] = ((r & sign_bit) != 0);
        end

        o.result_value = r;
        o.write_back   = wb;
        o.flags_out    = flags;
        o.divide_fault = fault;
        return o;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_op(input logic [3:0] mode, input logic wide,
                            input logic [15:0] src, input logic [15:0] dst,
                            input logic [15:0] flg);
        awsf_pkg::req_t op;
        op.mode         = mode;
        op.wide         = wide;
        op.source_value = src;
        op.dest_value   = dst;
        op.flags_in     = flg;
        pending_ops.push_back(op);
    endtask

    function automatic logic [15:0] edge_operand();
        case ($urandom_range(0, 6))
            0:       return 16'h0000;
            1:       return 16'h7FFF;
            2:       return 16'h8000;
            3:       return 16'hFFFF;
            4:       return 16'h007F;
            5:       return 16'h0080;
            default: return 16'h00FF;
        endcase
    endfunction

    function automatic awsf_pkg::req_t draw_operation();
        awsf_pkg::req_t op;
        op.mode = ($urandom_range(0, 99) < 5) ? 4'($urandom_range(13, 15))
                                              : 4'($urandom_range(0, 12));
        op.wide         = 1'($urandom_range(0, 1));
        op.source_value = 16'($urandom);
        op.dest_value   = ($urandom_range(0, 9) == 0) ? edge_operand() : 16'($urandom);
        op.flags_in     = 16'($urandom);
        if ((op.mode == awsf_pkg::OP_SHL || op.mode == awsf_pkg::OP_SHR) &&
            $urandom_range(0, 9) < 7)
            op.source_value = 16'($urandom_range(0, 20));
        else if (op.mode == awsf_pkg::OP_DIV)
        begin
            case ($urandom_range(0, 9))
                0, 1:    op.source_value = {8'($urandom), 8'h00};  // zero in byte mode
                2:       op.source_value = 16'h0000;
                3:       op.source_value = 16'hFFFF;
                4, 5, 6: op.source_value = 16'($urandom_range(1, 9));
                default: ;
            endcase
        end
        else if ($urandom_range(0, 9) == 0)
            op.source_value = edge_operand();
        return op;
    endfunction

    task automatic wait_for_drain();
        while (pending_ops.size() != 0 || req_ch.valid || expected_outcomes.size() != 0)
            @(negedge clk);
    endtask

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("[%0t] mismatch on %s: got 0x%04h, expected 0x%04h",
                 $realtime, what, got, want);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------------
    // Clock, reset, stimulus and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        rst_n               = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.mode         = '0;
        req_ch.wide         = 1'b0;
        req_ch.source_value = '0;
        req_ch.dest_value   = '0;
        req_ch.flags_in     = '0;
        rsp_ch.ready        = 1'b0;
        mismatch_count      = 0;

        // directed: width extremes, overflow corners, signed divide, shifts
        queue_op(awsf_pkg::OP_MOV,  1'b1, 16'hFFFF, 16'h1234, 16'h0000);
        queue_op(awsf_pkg::OP_MOV,  1'b0, 16'hAB00, 16'hFFFF, 16'hFFFF);
        queue_op(awsf_pkg::OP_ADD,  1'b0, 16'h1201, 16'hFF7F, 16'h0004);
        queue_op(awsf_pkg::OP_ADD,  1'b1, 16'h0001, 16'h7FFF, 16'hFFF0);
        queue_op(awsf_pkg::OP_ADD,  1'b1, 16'h0001, 16'hFFFF, 16'h000F);
        queue_op(awsf_pkg::OP_ADD,  1'b1, 16'h8000, 16'h8000, 16'h0000);
        queue_op(awsf_pkg::OP_SUB,  1'b1, 16'h0001, 16'h8000, 16'h0000);
        queue_op(awsf_pkg::OP_SUB,  1'b0, 16'h0001, 16'h0080, 16'hFFFF);
        queue_op(awsf_pkg::OP_SUB,  1'b1, 16'hFFFF, 16'h7FFF, 16'h0004);
        queue_op(awsf_pkg::OP_CMP,  1'b1, 16'h5A5A, 16'h5A5A, 16'h0006);
        queue_op(awsf_pkg::OP_MUL,  1'b1, 16'hFFFF, 16'hFFFF, 16'h0000);
        queue_op(awsf_pkg::OP_MUL,  1'b0, 16'h0010, 16'h0010, 16'h0000);
        queue_op(awsf_pkg::OP_DIV,  1'b1, 16'hFFFF, 16'h8000, 16'h0000);
        queue_op(awsf_pkg::OP_DIV,  1'b1, 16'h0002, 16'hFFF9, 16'h0000);
        queue_op(awsf_pkg::OP_DIV,  1'b0, 16'h0003, 16'h00FE, 16'h0000);
        queue_op(awsf_pkg::OP_DIV,  1'b1, 16'h0000, 16'h1234, 16'hA5A5);
        queue_op(awsf_pkg::OP_DIV,  1'b0, 16'hFF00, 16'h0042, 16'h5A5A);
        queue_op(awsf_pkg::OP_NOT,  1'b0, 16'h00FF, 16'h0000, 16'h0000);
        queue_op(awsf_pkg::OP_AND,  1'b1, 16'hF0F0, 16'h0F0F, 16'h0000);
        queue_op(awsf_pkg::OP_OR,   1'b1, 16'h8000, 16'h0001, 16'h0000);
        queue_op(awsf_pkg::OP_XOR,  1'b0, 16'h00AA, 16'h0055, 16'h0000);
        queue_op(awsf_pkg::OP_TEST, 1'b1, 16'h0080, 16'h00FF, 16'h0000);
        queue_op(awsf_pkg::OP_SHL,  1'b0, 16'h0000, 16'h0081, 16'h0004);
        queue_op(awsf_pkg::OP_SHL,  1'b1, 16'h0011, 16'h0001, 16'h0000);
        queue_op(awsf_pkg::OP_SHR,  1'b1, 16'h0004, 16'h8001, 16'h0000);
        queue_op(awsf_pkg::OP_SHR,  1'b1, 16'h0010, 16'h8000, 16'h0000);
        queue_op(awsf_pkg::OP_SHR,  1'b0, 16'h0001, 16'h0081, 16'h0000);
        queue_op(MODE_SPARE_LO, 1'b1, 16'hFFFF, 16'hFFFF, 16'h1234);
        queue_op(MODE_SPARE_HI, 1'b0, 16'h0000, 16'h0000, 16'hFFFF);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // hold the sender until the directed words have all come back
        wait_for_drain();
        repeat (RANDOM_FIRST) pending_ops.push_back(draw_operation());
        @(negedge clk);
        wait_for_drain();
        repeat (RANDOM_SECOND) pending_ops.push_back(draw_operation());
        @(negedge clk);
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (mismatch_count == 0)
            $display("alu_with_status_flags regression: pass");
        else
            $display("alu_with_status_flags regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Driver: bursts of random length with random gaps
    // ------------------------------------------------------------------------
    int             burst_left;
    int             gap_left;
    awsf_pkg::req_t next_op;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            burst_left   <= 1;
            gap_left     <= 0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
                expected_outcomes.push_back(alu_outcome({req_ch.mode, req_ch.wide,
                    req_ch.source_value, req_ch.dest_value, req_ch.flags_in}));

            if (!req_ch.valid || req_ch.ready)
            begin
                if (gap_left > 0)
                begin
                    req_ch.valid <= 1'b0;
                    gap_left     <= gap_left - 1;
                end
                else if (pending_ops.size() != 0)
                begin
                    next_op = pending_ops.pop_front();
                    req_ch.valid        <= 1'b1;
                    req_ch.mode         <= next_op.mode;
                    req_ch.wide         <= next_op.wide;
                    req_ch.source_value <= next_op.source_value;
                    req_ch.dest_value   <= next_op.dest_value;
                    req_ch.flags_in     <= next_op.flags_in;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                    begin
                        burst_left <= burst_left - 1;
                    end
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver stall pattern: segments of free flow, fixed duty and random
    // ------------------------------------------------------------------------
    int stall_style;
    int style_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            stall_style  <= 0;
            style_left   <= 0;
        end
        else
        begin
            if (style_left == 0)
            begin
                stall_style <= $urandom_range(0, 3);
                style_left  <= $urandom_range(10, 80);
            end
            else
            begin
                style_left <= style_left - 1;
            end
            case (stall_style)
                0:       rsp_ch.ready <= 1'b1;
                1:       rsp_ch.ready <= (cycle_count % 4 != 3);
                2:       rsp_ch.ready <= (cycle_count % 4 == 0);
                default: rsp_ch.ready <= 1'($urandom_range(0, 1));
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Monitor and checker
    // ------------------------------------------------------------------------
    alu_outcome_t want;

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_outcomes.size() == 0)
            begin
                report_mismatch("unexpected word", rsp_ch.result_value, 16'h0000);
            end
            else
            begin
                want = expected_outcomes.pop_front();
                if (rsp_ch.result_value !== want.result_value)
                    report_mismatch("result_value", rsp_ch.result_value, want.result_value);
                if (rsp_ch.write_back !== want.write_back)
                    report_mismatch("write_back", 16'(rsp_ch.write_back),
                                    16'(want.write_back));
                if (rsp_ch.flags_out !== want.flags_out)
                    report_mismatch("flags_out", rsp_ch.flags_out, want.flags_out);
                if (rsp_ch.divide_fault !== want.divide_fault)
                    report_mismatch("divide_fault", 16'(rsp_ch.divide_fault),
                                    16'(want.divide_fault));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("alu_with_status_flags regression: fail");
            $finish;
        end
    end

    initial cycle_count = 0;

endmodule

// ===== alu_with_status_flags.f =====
+incdir+rtl
rtl/awsf_pkg.sv
rtl/awsf_req_if.sv
rtl/awsf_rsp_if.sv
rtl/awsf_exec.sv
rtl/awsf_div_step.sv
rtl/alu_with_status_flags.sv
bench/tb_alu_with_status_flags.sv
